>>> hdl/gf256_mul_pow_inv_unit_assert.svh
// Assertion macros shared by the GF(2^8) arithmetic unit.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef GF256_MUL_POW_INV_UNIT_ASSERT_SVH
`define GF256_MUL_POW_INV_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GFMPI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gfmpi assertion failed");

// Next-cycle implication, disabled during reset.
`define GFMPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gfmpi assertion failed");

`endif

>>> hdl/gfmpi_pkg.sv
// Package for the GF(2^8) arithmetic unit: field constants, operation codes,
// the pipeline data type and the field product function. Depends on nothing.
`default_nettype none
package gfmpi_pkg;

  localparam int GF_BITS = 8;
  localparam logic [7:0] GF_REDUCE = 8'h1B;
  localparam logic [7:0] GF_TOPBIT = 8'h80;
  localparam int GF_INV_POWER = 254;
  localparam int EXPONENT_BITS_DEF = 32;

  localparam logic [1:0] FUNC_MUL = 2'd0;
  localparam logic [1:0] FUNC_POW = 2'd1;
  localparam logic [1:0] FUNC_INV = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [7:0] acc;
    logic [7:0] base;
  } gfmpi_data_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] x_in, input logic [7:0] y_in);
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    acc = 8'h00;
    x = x_in;
    y = y_in;
    for (int k = 0; k < GF_BITS; k++) begin
      if (y[0]) begin
        acc = acc ^ x;
      end
      if ((x & GF_TOPBIT) != 8'h00) begin
        x = {x[6:0], 1'b0} ^ GF_REDUCE;
      end else begin
        x = {x[6:0], 1'b0};
      end
      y = {1'b0, y[7:1]};
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

>>> hdl/gfmpi_stage.sv
// One square-and-multiply pipeline stage: consumes the low exponent bit.
// Depends on gfmpi_pkg for the data type and the field product.
`default_nettype none
module gfmpi_stage
  import gfmpi_pkg::*;
#(
  parameter int EXPONENT_BITS = EXPONENT_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire gfmpi_data_t              d_in,
  input  wire logic [EXPONENT_BITS-1:0] exp_in,
  output gfmpi_data_t                   d_r,
  output logic      [EXPONENT_BITS-1:0] exp_r
);

  logic [7:0]               acc_nxt;
  logic [7:0]               base_nxt;
  logic [EXPONENT_BITS-1:0] exp_nxt;

  always_comb begin
    acc_nxt  = exp_in[0] ? gf_mul(d_in.acc, d_in.base) : d_in.acc;
    base_nxt = gf_mul(d_in.base, d_in.base);
    exp_nxt  = exp_in >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r.valid <= d_in.valid;
    end
    if (en) begin
      d_r.acc  <= acc_nxt;
      d_r.base <= base_nxt;
      exp_r    <= exp_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/gf256_mul_pow_inv_unit.sv
// A result passes through the entry register and then one stage per exponent bit
// before it is offered. Throughput: one transaction per cycle unless stalled; each
// stage holds one squaring and one product unit. The whole pipeline advances
// together when the output register is free or taken. Reset clears every stage
// valid bit; data registers are not reset.
// Top level; depends on gfmpi_pkg, gfmpi_stage and the assertion macro header.
`default_nettype none
`include "gf256_mul_pow_inv_unit_assert.svh"
module gf256_mul_pow_inv_unit
  import gfmpi_pkg::*;
#(
  parameter int EXPONENT_BITS = EXPONENT_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               in_func,
  input  wire logic [7:0]               in_operand_a,
  input  wire logic [7:0]               in_operand_b,
  input  wire logic [EXPONENT_BITS-1:0] in_exponent,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [7:0]                    out_result_byte
);

  gfmpi_data_t              pipe  [EXPONENT_BITS+1];
  logic [EXPONENT_BITS-1:0] pexp  [EXPONENT_BITS+1];
  logic [EXPONENT_BITS:0]   valid_vec;
  logic                     advance;
  gfmpi_data_t              entry_nxt;
  logic [EXPONENT_BITS-1:0] entry_exp_nxt;

  assign advance         = !out_valid || out_ready;
  assign in_ready        = advance;
  assign out_valid       = pipe[EXPONENT_BITS].valid;
  assign out_result_byte = pipe[EXPONENT_BITS].acc;

  always_comb begin
    entry_nxt.valid = in_valid;
    entry_nxt.base  = in_operand_a;
    entry_nxt.acc   = 8'h01;
    entry_exp_nxt   = '0;
    unique case (in_func)
      FUNC_MUL: begin
        entry_nxt.acc = gf_mul(in_operand_a, in_operand_b);
      end
      FUNC_POW: begin
        entry_exp_nxt = in_exponent;
      end
      FUNC_INV: begin
        entry_exp_nxt = EXPONENT_BITS'(GF_INV_POWER);
      end
      default: begin
        entry_nxt.acc = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe[0].valid <= 1'b0;
    end else if (advance) begin
      pipe[0].valid <= entry_nxt.valid;
    end
    if (advance) begin
      pipe[0].acc  <= entry_nxt.acc;
      pipe[0].base <= entry_nxt.base;
      pexp[0]      <= entry_exp_nxt;
    end
  end

  assign valid_vec[0] = pipe[0].valid;

  for (genvar k = 0; k < EXPONENT_BITS; k++) begin : g_stage
    gfmpi_stage #(
      .EXPONENT_BITS(EXPONENT_BITS)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (advance),
      .d_in  (pipe[k]),
      .exp_in(pexp[k]),
      .d_r   (pipe[k+1]),
      .exp_r (pexp[k+1])
    );
    assign valid_vec[k+1] = pipe[k+1].valid;
  end

  `GFMPI_ASSERT_NEXT(a_stall_holds, clk, rst_n, !advance, $stable(valid_vec))
  `GFMPI_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && in_ready, pipe[0].valid)
  `GFMPI_ASSERT_NOW(a_drop_only_taken, clk, rst_n, $fell(out_valid) && $past(rst_n), $past(out_ready))

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for gf256_mul_pow_inv_unit: GF(2^8) multiply, power and inverse.
// Depends on gfmpi_pkg for operation codes and field constants.
// The driver and monitor are clocked always blocks; results are checked against a local predictor.
module tb;
  import gfmpi_pkg::*;

  localparam logic [1:0] FUNC_UNDEF = 2'd3;
  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = EXPONENT_BITS_DEF + 16;
  localparam int CALM_FIRST = 300;
  localparam int CALM_LAST = 450;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  operand_a;
    logic [7:0]  operand_b;
    logic [31:0] exponent;
  } gf_request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = FUNC_MUL;
  logic [7:0]  in_operand_a = 8'h00;
  logic [7:0]  in_operand_b = 8'h00;
  logic [31:0] in_exponent = 32'h0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_result_byte;

  gf_request_t request_q[$];
  logic [7:0]  product_q[$];
  gf_request_t drv_req;
  logic        req_taken = 1'b0;
  logic [7:0]  want_byte;
  int          sent_cnt = 0;
  int          accepted_cnt = 0;
  int          checked_cnt = 0;
  int          total_cnt = 0;
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  int          op_seen[4] = '{0, 0, 0, 0};

  gf256_mul_pow_inv_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_operand_a   (in_operand_a),
    .in_operand_b   (in_operand_b),
    .in_exponent    (in_exponent),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_byte(out_result_byte)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return v[7] ? ({v[6:0], 1'b0} ^ GF_REDUCE) : {v[6:0], 1'b0};
  endfunction

  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 7; i >= 0; i--) begin
      acc = gf_double(acc) ^ (b[i] ? a : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [7:0] gf_raise(input logic [7:0] base, input logic [31:0] e);
    logic [7:0] acc;
    logic [7:0] sq;
    acc = 8'h01;
    sq = base;
    for (int i = 0; i < 32; i++) begin
      if (e[i]) begin
        acc = gf_times(acc, sq);
      end
      sq = gf_times(sq, sq);
    end
    return acc;
  endfunction

  function automatic logic [7:0] gf_expected(input gf_request_t r);
    case (r.func)
      FUNC_MUL: begin
        return gf_times(r.operand_a, r.operand_b);
      end
      FUNC_POW: begin
        return gf_raise(r.operand_a, r.exponent);
      end
      FUNC_INV: begin
        return (r.operand_a == 8'h00) ? 8'h00 : gf_raise(r.operand_a, 32'(GF_INV_POWER));
      end
      default: begin
        return 8'h00;
      end
    endcase
  endfunction

  function automatic bit take_break();
    if (sent_cnt >= CALM_FIRST && sent_cnt < CALM_LAST) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < 30;
  endfunction

  task automatic queue_request(input logic [1:0] f, input logic [7:0] a, input logic [7:0] b,
                               input logic [31:0] e);
    gf_request_t r;
    r.func = f;
    r.operand_a = a;
    r.operand_b = b;
    r.exponent = e;
    request_q.push_back(r);
    total_cnt++;
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (request_q.size() != 0 && !take_break()) begin
        drv_req = request_q.pop_front();
        in_valid <= 1'b1;
        in_func <= drv_req.func;
        in_operand_a <= drv_req.operand_a;
        in_operand_b <= drv_req.operand_b;
        in_exponent <= drv_req.exponent;
        sent_cnt++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !take_break();
  end

  always @(posedge clk) begin
    req_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        product_q.push_back(gf_expected({in_func, in_operand_a, in_operand_b, in_exponent}));
        accepted_cnt++;
        op_seen[in_func]++;
      end
      if (out_valid && out_ready) begin
        if (product_q.size() == 0) begin
          $error("result_byte: expected none, actual 0x%02h", out_result_byte);
          fail_cnt++;
        end else begin
          want_byte = product_q.pop_front();
          if (out_result_byte !== want_byte) begin
            $error("result_byte: expected 0x%02h, actual 0x%02h", want_byte, out_result_byte);
            fail_cnt++;
          end
          checked_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int          pick;
    logic [1:0]  f;
    logic [7:0]  a;
    logic [31:0] e;

    queue_request(FUNC_MUL, 8'h00, 8'hFF, $urandom);
    queue_request(FUNC_MUL, 8'hFF, 8'hFF, $urandom);
    queue_request(FUNC_MUL, 8'h57, 8'h83, $urandom);
    queue_request(FUNC_MUL, 8'h80, 8'h02, $urandom);
    queue_request(FUNC_MUL, 8'h01, 8'hA5, $urandom);
    queue_request(FUNC_POW, 8'h00, 8'($urandom), 32'h0);
    queue_request(FUNC_POW, 8'hFF, 8'($urandom), 32'h0);
    queue_request(FUNC_POW, 8'h00, 8'($urandom), 32'd5);
    queue_request(FUNC_POW, 8'h03, 8'($urandom), 32'hFFFF_FFFF);
    queue_request(FUNC_POW, 8'h02, 8'($urandom), 32'd255);
    queue_request(FUNC_POW, 8'hFF, 8'($urandom), 32'h8000_0000);
    queue_request(FUNC_POW, 8'h53, 8'($urandom), 32'd254);
    queue_request(FUNC_INV, 8'h00, 8'($urandom), $urandom);
    queue_request(FUNC_INV, 8'h01, 8'($urandom), $urandom);
    queue_request(FUNC_INV, 8'hFF, 8'($urandom), $urandom);
    queue_request(FUNC_INV, 8'h53, 8'($urandom), $urandom);
    queue_request(FUNC_UNDEF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    queue_request(FUNC_UNDEF, 8'($urandom), 8'($urandom), $urandom);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 15);
      f = (pick < 5) ? FUNC_MUL : (pick < 11) ? FUNC_POW : (pick < 15) ? FUNC_INV : FUNC_UNDEF;
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          a = 8'h00;
        end
        1: begin
          a = 8'hFF;
        end
        default: begin
          a = 8'($urandom_range(0, 255));
        end
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        e = $urandom;
      end else if (pick < 7) begin
        e = $urandom_range(0, 300);
      end else if (pick < 9) begin
        e = 32'h1 << $urandom_range(0, 31);
      end else begin
        e = 32'hFFFF_FFFF ^ (32'h1 << $urandom_range(0, 31));
      end
      queue_request(f, a, 8'($urandom_range(0, 255)), e);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total_cnt) @(negedge clk);
    while (product_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d transactions: %0d multiply, %0d power, %0d inverse, %0d undefined.",
             accepted_cnt, op_seen[FUNC_MUL], op_seen[FUNC_POW], op_seen[FUNC_INV],
             op_seen[FUNC_UNDEF]);
    $display("Compared %0d result bytes with random stalls on both channels; %0d mismatches.",
             checked_cnt, fail_cnt);
    if (fail_cnt == 0 && product_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/gfmpi_pkg.sv
hdl/gfmpi_stage.sv
hdl/gf256_mul_pow_inv_unit.sv
tb/sv/tb.sv
